// ----- sv/pavg_pkg.sv -----
// ----------------------------------------------------------------------------
// pavg_pkg
// Shared types and constants of the pressure moving-average trip block.
// ----------------------------------------------------------------------------
package pavg_pkg;

  localparam int WINDOW = 8;   // boxcar length, power of two
  localparam int HITS   = 3;   // consecutive hits that latch a fault
  localparam int PORTS  = 2;   // sensor ports

  localparam int SAMPLE_W = 14;
  localparam int PORT_W   = 1;
  localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SHIFT    = $clog2(WINDOW);
  localparam int TOTAL_W  = SAMPLE_W + SHIFT;
  localparam int HIT_W    = $clog2(HITS + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [SAMPLE_W-1:0] LIMIT_RESET = SAMPLE_W'(8000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAFETY_EN = 2'd0,
    CFG_LIMIT0    = 2'd1,
    CFG_LIMIT1    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                command;
    logic [PORT_W-1:0]   port;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [PORT_W-1:0]   port_out;
    logic [SAMPLE_W-1:0] average;
    logic                fault_latched;
    logic                trip;
  } out_item_t;

  // control from the top level to one port's channel
  typedef struct packed {
    logic en;        // item for this port advances this cycle
    logic clear;     // item is a clear command
    logic clr_hits;  // configuration write clears the hit count
  } chan_ctrl_t;

  // result of one port's channel for the item in flight
  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic                fault_latched;
    logic                trip;
  } chan_res_t;

endpackage

// ----- sv/pavg_cfg.sv -----
// ----------------------------------------------------------------------------
// pavg_cfg
// Configuration registers: safety enable and per-port limits.
// ----------------------------------------------------------------------------
module pavg_cfg (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [pavg_pkg::CFG_IDX_W-1:0]              cfg_idx_i,
  input  logic [pavg_pkg::CFG_DATA_W-1:0]             cfg_data_i,
  output logic                                        safety_en_o,
  output logic [pavg_pkg::PORTS-1:0][pavg_pkg::SAMPLE_W-1:0] limit_o,
  output logic [pavg_pkg::PORTS-1:0]                  clr_hits_o
);

  logic                                               safety_en_q, safety_en_d;
  logic [pavg_pkg::PORTS-1:0][pavg_pkg::SAMPLE_W-1:0] limit_q, limit_d;
  logic [pavg_pkg::PORTS-1:0]                         clr_hits;

  always_comb begin
    safety_en_d = safety_en_q;
    limit_d     = limit_q;
    clr_hits    = '0;
    if (cfg_we_i) begin
      unique case (pavg_pkg::cfg_idx_e'(cfg_idx_i))
        pavg_pkg::CFG_SAFETY_EN: begin
          safety_en_d = cfg_data_i[0];
          clr_hits    = '1;
        end
        pavg_pkg::CFG_LIMIT0: begin
          limit_d[0]  = cfg_data_i[pavg_pkg::SAMPLE_W-1:0];
          clr_hits[0] = 1'b1;
        end
        pavg_pkg::CFG_LIMIT1: begin
          if (pavg_pkg::PORTS > 1) begin
            limit_d[pavg_pkg::PORTS-1]  = cfg_data_i[pavg_pkg::SAMPLE_W-1:0];
            clr_hits[pavg_pkg::PORTS-1] = 1'b1;
          end
        end
        default: ;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      safety_en_q <= 1'b1;
      limit_q     <= {pavg_pkg::PORTS{pavg_pkg::LIMIT_RESET}};
    end else begin
      safety_en_q <= safety_en_d;
      limit_q     <= limit_d;
    end
  end

  assign safety_en_o = safety_en_q;
  assign limit_o     = limit_q;
  assign clr_hits_o  = clr_hits;

endmodule

// ----- sv/pavg_chan.sv -----
// ----------------------------------------------------------------------------
// pavg_chan
// One port: sample ring, running total, hit counter and fault latch.
// ----------------------------------------------------------------------------
module pavg_chan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pavg_pkg::chan_ctrl_t          ctrl_i,
  input  logic [pavg_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [pavg_pkg::SAMPLE_W-1:0] limit_i,
  input  logic                          safety_en_i,
  output pavg_pkg::chan_res_t           res_o
);

  logic [pavg_pkg::WINDOW-1:0][pavg_pkg::SAMPLE_W-1:0] ring_q, ring_d;
  logic [pavg_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic [pavg_pkg::TOTAL_W-1:0] total_q, total_d, total_new;
  logic [pavg_pkg::HIT_W-1:0]   hits_q, hits_d, hits_inc;
  logic                         fault_q, fault_d;
  logic [pavg_pkg::SAMPLE_W-1:0] avg_new, avg_cur;
  logic                         armed;
  logic                         trip;

  // oldest sample leaves, new one enters
  assign total_new = total_q - pavg_pkg::TOTAL_W'(ring_q[idx_q])
                             + pavg_pkg::TOTAL_W'(sample_i);
  assign avg_new   = pavg_pkg::SAMPLE_W'(total_new >> pavg_pkg::SHIFT);
  assign avg_cur   = pavg_pkg::SAMPLE_W'(total_q >> pavg_pkg::SHIFT);
  assign armed     = safety_en_i && (limit_i != '0) && !fault_q;
  assign hits_inc  = hits_q + pavg_pkg::HIT_W'(1);

  always_comb begin
    ring_d  = ring_q;
    idx_d   = idx_q;
    total_d = total_q;
    hits_d  = hits_q;
    fault_d = fault_q;
    trip    = 1'b0;
    res_o.average = avg_cur;
    if (ctrl_i.clr_hits) begin
      hits_d = '0;
    end
    if (ctrl_i.en) begin
      if (ctrl_i.clear) begin
        fault_d = 1'b0;
        hits_d  = '0;
      end else begin
        ring_d[idx_q] = sample_i;
        total_d       = total_new;
        idx_d         = (idx_q == pavg_pkg::IDX_W'(pavg_pkg::WINDOW - 1)) ?
                        '0 : idx_q + pavg_pkg::IDX_W'(1);
        res_o.average = avg_new;
        if (armed) begin
          if (avg_new > limit_i) begin
            if (int'(hits_inc) >= pavg_pkg::HITS) begin
              hits_d  = '0;
              fault_d = 1'b1;
              trip    = 1'b1;
            end else begin
              hits_d = hits_inc;
            end
          end else begin
            hits_d = '0;
          end
        end
      end
    end
    res_o.fault_latched = fault_d;
    res_o.trip          = trip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q  <= '0;
      idx_q   <= '0;
      total_q <= '0;
      hits_q  <= '0;
      fault_q <= 1'b0;
    end else begin
      ring_q  <= ring_d;
      idx_q   <= idx_d;
      total_q <= total_d;
      hits_q  <= hits_d;
      fault_q <= fault_d;
    end
  end

endmodule

// ----- sv/pressure_average_overlimit_trip.sv -----
// ----------------------------------------------------------------------------
// pressure_average_overlimit_trip
// Per-port boxcar moving average of pressure samples with over-limit trip.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the output drains and gives one result
// beat for every input beat, in order. A beat waits in the input register;
// when it advances, the port's ring, running total, hit counter and fault
// latch are updated and the result is captured in the output register, so
// sustained rate is one beat per cycle whenever out_ready_i is high.
// The throughput is set by the read-modify-write of the port's state in
// that same step; back-to-back beats for the same port see each other's
// updates. Configuration writes (safety enable, per-port limits) are
// registered and clear the affected hit counters; issue them only while idle.
// ----------------------------------------------------------------------------
module pressure_average_overlimit_trip (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pavg_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pavg_pkg::out_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [pavg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pavg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic                 in_valid_q;
  pavg_pkg::in_item_t   in_q;
  logic                 out_valid_q;
  pavg_pkg::out_item_t  out_q, out_d;
  logic                 adv;
  logic                 port_ok;

  logic                                               safety_en;
  logic [pavg_pkg::PORTS-1:0][pavg_pkg::SAMPLE_W-1:0] limit;
  logic [pavg_pkg::PORTS-1:0]                         clr_hits;
  pavg_pkg::chan_ctrl_t [pavg_pkg::PORTS-1:0]         ctrl;
  pavg_pkg::chan_res_t  [pavg_pkg::PORTS-1:0]         res;

  // held beat moves to the output register when that is free or draining
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;
  assign port_ok    = int'(in_q.port) < pavg_pkg::PORTS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  pavg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .safety_en_o (safety_en),
    .limit_o     (limit),
    .clr_hits_o  (clr_hits)
  );

  for (genvar p = 0; p < pavg_pkg::PORTS; p++) begin : g_chan
    assign ctrl[p].en       = adv && (int'(in_q.port) == p);
    assign ctrl[p].clear    = (in_q.command == pavg_pkg::CMD_CLEAR);
    assign ctrl[p].clr_hits = clr_hits[p];

    pavg_chan u_chan (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl[p]),
      .sample_i    (in_q.sample),
      .limit_i     (limit[p]),
      .safety_en_i (safety_en),
      .res_o       (res[p])
    );
  end

  // absent port: nothing changes and the result carries the port with zero fields
  always_comb begin
    out_d               = '0;
    out_d.port_out      = in_q.port;
    if (port_ok) begin
      out_d.average       = res[in_q.port].average;
      out_d.fault_latched = res[in_q.port].fault_latched;
      out_d.trip          = res[in_q.port].trip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
